FILE: sv/sbdb_pkg.sv
// Shared types, constants and helpers for the spectrum bin dB smoother.
`default_nettype none
package sbdb_pkg;

    localparam int LOG_FRAC_BITS = 16;
    localparam int BIN_W         = 9;
    localparam int DB_W          = 16;
    localparam int ALPHA_W       = 17;
    localparam int LEVELS_DEPTH  = 512;

    localparam logic signed [DB_W-1:0] MIN_DB_RESET = -16'sd25600;
    localparam logic [ALPHA_W-1:0]     ALPHA_ONE    = 17'd65536;

    typedef enum logic [1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_MIN_DB = 2'd1,
        CFG_MAX_DB = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0]  re;
        logic signed [31:0]  im;
        logic [BIN_W-1:0]    bin;
    } t_in;

    typedef struct packed {
        logic [BIN_W-1:0]       bin_out;
        logic signed [DB_W-1:0] smoothed_db;
    } t_out;

    // Log2 pipeline stage: mantissa Q1.31, exponent, fraction bits so far
    typedef struct packed {
        logic                     vld;
        logic                     zero;
        logic [BIN_W-1:0]         bin;
        logic [5:0]               e;
        logic [31:0]              m;
        logic [LOG_FRAC_BITS-1:0] frac;
    } t_log;

    typedef struct packed {
        logic                   vld;
        logic [BIN_W-1:0]       bin;
        logic signed [DB_W-1:0] level;
    } t_lvl;

    // Truncated log2 in Q.16, evaluated at elaboration for constant arguments
    function automatic int unsigned log2_q16(input int unsigned x);
        int unsigned       e;
        int unsigned       frac;
        longint unsigned   m;
        e    = 0;
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                e = i;
            end
        end
        m = (longint'(x) << 31) >> e;
        for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | (32'd1 << k);
                m    = m >> 1;
            end
        end
        return (e << 16) | frac;
    endfunction

endpackage
`default_nettype wire

FILE: sv/sbdb_front.sv
// Magnitude squared, leading-one search and mantissa normalization.
`default_nettype none
module sbdb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire sbdb_pkg::t_in i_item,
    output sbdb_pkg::t_log     o_st
);
    import sbdb_pkg::*;

    logic             r1_vld, r2_vld, r3_vld, r4_vld;
    logic [31:0]      r1_are, r1_aim;
    logic [BIN_W-1:0] r1_bin, r2_bin, r3_bin, r4_bin;
    logic [63:0]      r2_sqr, r2_sqi, r3_p, r4_p;
    logic [5:0]       r4_e;
    logic             r4_zero;
    t_log             r_st;

    logic [31:0] n1_are, n1_aim;
    logic [5:0]  n4_e;
    logic [63:0] n5_sh;
    t_log        n_st;

    assign n1_are = i_item.re[31] ? (~i_item.re + 32'd1) : i_item.re;
    assign n1_aim = i_item.im[31] ? (~i_item.im + 32'd1) : i_item.im;

    always_comb begin
        n4_e = '0;
        for (int i = 0; i < 64; i++) begin
            if (r3_p[i]) begin
                n4_e = 6'(i);
            end
        end
    end

    always_comb begin
        if (r4_e >= 6'd31) begin
            n5_sh = r4_p >> (r4_e - 6'd31);
        end else begin
            n5_sh = r4_p << (6'd31 - r4_e);
        end
        n_st.vld  = r4_vld;
        n_st.zero = r4_zero;
        n_st.bin  = r4_bin;
        n_st.e    = r4_e;
        n_st.m    = n5_sh[31:0];
        n_st.frac = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r4_vld   <= 1'b0;
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r1_vld   <= i_vld;
            r2_vld   <= r1_vld;
            r3_vld   <= r2_vld;
            r4_vld   <= r3_vld;
            r_st.vld <= n_st.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_are  <= n1_are;
            r1_aim  <= n1_aim;
            r1_bin  <= i_item.bin;
            r2_sqr  <= 64'(r1_are) * 64'(r1_are);
            r2_sqi  <= 64'(r1_aim) * 64'(r1_aim);
            r2_bin  <= r1_bin;
            r3_p    <= r2_sqr + r2_sqi;
            r3_bin  <= r2_bin;
            r4_p    <= r3_p;
            r4_e    <= n4_e;
            r4_zero <= (r3_p == 64'd0);
            r4_bin  <= r3_bin;
            r_st.zero <= n_st.zero;
            r_st.bin  <= n_st.bin;
            r_st.e    <= n_st.e;
            r_st.m    <= n_st.m;
            r_st.frac <= n_st.frac;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

FILE: sv/sbdb_log_step.sv
// One squaring step of the log2 fraction: yields one fraction bit.
`default_nettype none
module sbdb_log_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire sbdb_pkg::t_log  i_st,
    output sbdb_pkg::t_log       o_st
);
    import sbdb_pkg::*;

    logic [63:0] sq;
    logic [32:0] t;
    t_log        n_st;
    t_log        r_st;

    assign sq = 64'(i_st.m) * 64'(i_st.m);
    assign t  = sq[63:31];

    always_comb begin
        n_st = i_st;
        // Mantissa reached two: emit a one and halve it
        if (t[32]) begin
            n_st.m    = t[32:1];
            n_st.frac = {i_st.frac[LOG_FRAC_BITS-2:0], 1'b1};
        end else begin
            n_st.m    = t[31:0];
            n_st.frac = {i_st.frac[LOG_FRAC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_st.vld <= n_st.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st.zero <= n_st.zero;
            r_st.bin  <= n_st.bin;
            r_st.e    <= n_st.e;
            r_st.m    <= n_st.m;
            r_st.frac <= n_st.frac;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

FILE: sv/sbdb_level.sv
// Normalization offset, dB scaling, rounding, saturation and clamping.
`default_nettype none
module sbdb_level #(
    parameter int FFT_SIZE = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire sbdb_pkg::t_log               i_st,
    input  wire logic signed [15:0]           i_min_db,
    input  wire logic signed [15:0]           i_max_db,
    output sbdb_pkg::t_lvl                    o_lvl
);
    import sbdb_pkg::*;

    localparam logic [22:0]        NORM_OFS = 23'(2 * log2_q16(FFT_SIZE));
    localparam logic signed [41:0] TEN_LOG10_2 = 42'sd197283;
    localparam logic signed [41:0] HALF_LSB = 42'sd8388608;

    logic                   r1_vld, r2_vld;
    logic                   r1_zero, r2_zero;
    logic [BIN_W-1:0]       r1_bin, r2_bin;
    logic signed [23:0]     r1_d;
    logic signed [41:0]     r2_prod;
    t_lvl                   r_lvl;

    logic signed [23:0]     n1_d;
    logic signed [41:0]     t;
    logic signed [17:0]     q;
    logic signed [DB_W-1:0] lv;

    assign n1_d = signed'({2'b00, i_st.e, i_st.frac}) - signed'({1'b0, NORM_OFS});
    assign t    = r2_prod + HALF_LSB;
    assign q    = 18'(t >>> 24);

    always_comb begin
        if (r2_zero) begin
            lv = i_min_db;
        end else if (q > 18'sd32767) begin
            lv = 16'sh7fff;
        end else if (q < -18'sd32768) begin
            lv = -16'sh8000;
        end else begin
            lv = q[15:0];
        end
        // Raise to the lower limit first, then lower to the upper one
        if (lv < i_min_db) begin
            lv = i_min_db;
        end
        if (lv > i_max_db) begin
            lv = i_max_db;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_lvl.vld <= 1'b0;
        end else if (i_en) begin
            r1_vld    <= i_st.vld;
            r2_vld    <= r1_vld;
            r_lvl.vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d        <= n1_d;
            r1_zero     <= i_st.zero;
            r1_bin      <= i_st.bin;
            r2_prod     <= 42'(r1_d) * TEN_LOG10_2;
            r2_zero     <= r1_zero;
            r2_bin      <= r1_bin;
            r_lvl.bin   <= r2_bin;
            r_lvl.level <= lv;
        end
    end

    assign o_lvl = r_lvl;

endmodule
`default_nettype wire

FILE: sv/sbdb_blend.sv
// Per-bin level store, clearing pass and exponential blend.
`default_nettype none
module sbdb_blend (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire sbdb_pkg::t_lvl       i_lvl,
    input  wire logic [16:0]          i_alpha,
    output logic                      o_busy,
    output logic                      o_vld,
    output sbdb_pkg::t_out            o_out
);
    import sbdb_pkg::*;

    logic signed [DB_W-1:0] mem [LEVELS_DEPTH];

    logic                   r_clr_done;
    logic [BIN_W-1:0]       r_clr_addr;
    logic signed [DB_W-1:0] r_rd;
    t_lvl                   r_e;
    logic                   r_out_vld;
    t_out                   r_out;

    logic signed [DB_W-1:0] old;
    logic [ALPHA_W-1:0]     a;
    logic signed [16:0]     diff;
    logic signed [34:0]     prod;
    logic signed [35:0]     s;
    logic signed [DB_W-1:0] nv;
    logic                   we;
    logic [BIN_W-1:0]       wa;
    logic signed [DB_W-1:0] wd;

    // The read misses only the write of the item just ahead; take it from the output register
    assign old  = (r_out_vld && (r_out.bin_out == r_e.bin)) ? r_out.smoothed_db : r_rd;
    assign a    = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
    assign diff = 17'(old) - 17'(r_e.level);
    assign prod = 35'(signed'({1'b0, a})) * 35'(diff);
    // alpha*old + (1-alpha)*level, rewritten around one product; stays between old and level
    assign s    = (36'(r_e.level) <<< 16) + 36'(prod) + 36'sd32768;
    assign nv   = 16'(s >>> 16);

    assign we = !r_clr_done || (i_en && r_e.vld);
    assign wa = r_clr_done ? r_e.bin : r_clr_addr;
    assign wd = r_clr_done ? nv : MIN_DB_RESET;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= mem[i_lvl.bin];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
        end else if (!r_clr_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == BIN_W'(LEVELS_DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_e.vld   <= i_lvl.vld;
            r_out_vld <= r_e.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e.bin           <= i_lvl.bin;
            r_e.level         <= i_lvl.level;
            r_out.bin_out     <= r_e.bin;
            r_out.smoothed_db <= nv;
        end
    end

    assign o_busy = !r_clr_done;
    assign o_vld  = r_out_vld;
    assign o_out  = r_out;

endmodule
`default_nettype wire

FILE: sv/spectrum_bin_db_smoother.sv
// Top level of the spectrum bin dB smoother: configuration registers and pipeline.
// Accepts one FFT bin per cycle while o_stall is low and returns its smoothed Q8.8
// dB level after 5 stages of magnitude and normalization, 16 squaring stages of the
// log2 unit, 3 stages of dB scaling and clamping, then the store read and the blend
// with the output register. Consecutive items for the same bin are handled at
// full rate by forwarding from the output register. After reset the block
// clears the per-bin store to -100 dB and holds o_stall high meanwhile;
// configuration writes are taken at any time.
`default_nettype none
module spectrum_bin_db_smoother #(
    parameter int FFT_SIZE = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire sbdb_pkg::t_in   i_data,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output sbdb_pkg::t_out       o_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [16:0]     i_cfg_data
);
    import sbdb_pkg::*;

    logic [ALPHA_W-1:0]     r_alpha;
    logic signed [DB_W-1:0] r_min_db;
    logic signed [DB_W-1:0] r_max_db;

    logic en;
    logic busy;
    t_log st [LOG_FRAC_BITS+1];
    t_lvl lvl;

    // Advance the whole pipeline unless a finished transaction is held at the output
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en || busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= '0;
            r_min_db <= MIN_DB_RESET;
            r_max_db <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                CFG_MIN_DB: r_min_db <= i_cfg_data[15:0];
                CFG_MAX_DB: r_max_db <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    sbdb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid && !o_stall),
        .i_item  (i_data),
        .o_st    (st[0])
    );

    for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_log
        sbdb_log_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_st    (st[g]),
            .o_st    (st[g+1])
        );
    end

    sbdb_level #(
        .FFT_SIZE (FFT_SIZE)
    ) u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_st     (st[LOG_FRAC_BITS]),
        .i_min_db (r_min_db),
        .i_max_db (r_max_db),
        .o_lvl    (lvl)
    );

    sbdb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_lvl   (lvl),
        .i_alpha (r_alpha),
        .o_busy  (busy),
        .o_vld   (o_valid),
        .o_out   (o_data)
    );

endmodule
`default_nettype wire
